### rtl/rdg_pkg.sv
// shared constants and types for the ray distance grid
package rdg_pkg;
  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int ColW = $clog2(MaxCols);
  localparam int RowW = $clog2(MaxRows);
  localparam int AddrW = ColW + RowW;
  localparam int Depth = MaxCols * MaxRows;
  localparam logic [6:0] ValueSat = 7'd64;
  localparam logic [0:0] ReqSet = 1'b0;
  localparam logic [0:0] ReqRead = 1'b1;
  localparam logic [0:0] CfgWidth = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  typedef struct packed {
    logic [0:0] req_type;
    logic [5:0] x_pos;
    logic [5:0] y_pos;
  } req_t;

  typedef struct packed {
    logic       cell_active;
    logic [6:0] cell_value;
    logic [6:0] largest_value;
  } rsp_t;

  function automatic logic signed [1:0] ray_dx(input logic [2:0] d);
    unique case (d)
      3'd0, 3'd1, 3'd2: ray_dx = -2'sd1;
      3'd3, 3'd4:       ray_dx = 2'sd0;
      default:          ray_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] ray_dy(input logic [2:0] d);
    unique case (d)
      3'd0, 3'd3, 3'd5: ray_dy = -2'sd1;
      3'd1, 3'd6:       ray_dy = 2'sd0;
      default:          ray_dy = 2'sd1;
    endcase
  endfunction
endpackage

### rtl/rdg_stream_if.sv
// valid/ready channel carrying one payload
interface rdg_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/ray_distance_grid_unit.sv
// ray distance grid: cell store, set walk, distance scan and grid maximum
// a read sweeps the full store before its result is valid
// a set recomputes the cell and up to 252 active ray cells, each by a distance
// scan, and walks the rays around the set cell to find them
// throughput: one beat at a time, the next accepted once the result has left
// reset: a clearing pass runs after rst, no beat taken then
module ray_distance_grid_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  rdg_stream_if.sink        req,
  rdg_stream_if.source      rsp
);
  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CHECK  = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_SCANRD = 10'b0000010000,
    S_WRITE  = 10'b0000100000,
    S_WALK   = 10'b0001000000,
    S_WALKRD = 10'b0010000000,
    S_MAX    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  localparam int AW = rdg_pkg::AddrW;

  logic [7:0] mem [rdg_pkg::Depth];
  logic [7:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic [7:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t state;
  logic [6:0] gw, gh;
  logic [6:0] w, h, lim;
  logic [0:0] rq;
  logic [5:0] cx, cy;
  logic [5:0] tx, ty;
  logic [6:0] o;
  logic [2:0] d;
  logic [6:0] wo;
  logic [2:0] wd;
  logic [6:0] mx;
  logic [AW:0] cnt;
  logic [AW-1:0] cur;
  logic [6:0] res;
  logic walking;
  rdg_pkg::rsp_t out;
  logic out_valid;

  assign w = (gw > 7'(rdg_pkg::MaxCols)) ? 7'(rdg_pkg::MaxCols) : gw;
  assign h = (gh > 7'(rdg_pkg::MaxRows)) ? 7'(rdg_pkg::MaxRows) : gh;
  assign lim = (w > h) ? w : h;

  function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y);
    addr_of = {y[rdg_pkg::RowW-1:0], x[rdg_pkg::ColW-1:0]};
  endfunction

  // ray target at offset and direction, with bounds flag
  logic signed [8:0] px, py, qx, qy;
  logic pin, qin;
  assign px = $signed({3'b0, tx}) + $signed({2'b0, o}) * rdg_pkg::ray_dx(d);
  assign py = $signed({3'b0, ty}) + $signed({2'b0, o}) * rdg_pkg::ray_dy(d);
  assign pin = px >= 0 && py >= 0 && px < $signed({2'b0, w}) && py < $signed({2'b0, h});
  assign qx = $signed({3'b0, cx}) + $signed({2'b0, wo}) * rdg_pkg::ray_dx(wd);
  assign qy = $signed({3'b0, cy}) + $signed({2'b0, wo}) * rdg_pkg::ray_dy(wd);
  assign qin = qx >= 0 && qy >= 0 && qx < $signed({2'b0, w}) && qy < $signed({2'b0, h});

  logic scan_end;
  assign scan_end = (d == 3'd7) && (o + 7'd1 >= lim || o >= rdg_pkg::ValueSat);

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.payload = out;

  logic [5:0] mxx, mxy;
  logic [5:0] prev_x, prev_y;
  assign mxx = cnt[5:0];
  assign mxy = cnt[11:6];

  always_comb begin
    raddr = addr_of(cx, cy);
    we = 1'b0;
    waddr = cur;
    wdata = {1'b1, res};
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; waddr = cnt[AW-1:0]; wdata = 8'd0;
      end
      S_IDLE: raddr = addr_of(req.payload.x_pos, req.payload.y_pos);
      S_SCAN: raddr = addr_of(px[5:0], py[5:0]);
      S_WRITE: we = 1'b1;
      S_WALK: raddr = addr_of(qx[5:0], qy[5:0]);
      // last sweep cycle reads the addressed cell back for the result
      S_MAX: raddr = cnt[AW] ? addr_of(cx, cy) : cnt[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      gw <= 7'd64;
      gh <= 7'd64;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rdg_pkg::CfgWidth:  gw <= cfg_data;
          rdg_pkg::CfgHeight: gh <= cfg_data;
        endcase
      end
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(rdg_pkg::Depth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid && req.ready) begin
          rq <= req.payload.req_type;
          cx <= req.payload.x_pos;
          cy <= req.payload.y_pos;
          state <= S_CHECK;
        end
        S_CHECK: begin
          // rdata holds addressed cell
          if ({1'b0, cx} < w && {1'b0, cy} < h && rq == rdg_pkg::ReqSet && !rdata[7]) begin
            tx <= cx; ty <= cy; cur <= addr_of(cx, cy);
            o <= 7'd1; d <= 3'd0; res <= rdg_pkg::ValueSat;
            wo <= 7'd1; wd <= 3'd0; walking <= 1'b0;
            // the cell is marked active when its scan result is written
            state <= (lim > 7'd1) ? S_SCAN : S_WRITE;
          end else begin
            cnt <= '0; mx <= '0; state <= S_MAX;
          end
        end
        S_SCAN: state <= pin ? S_SCANRD : (scan_end ? S_WRITE : S_SCAN);
        S_SCANRD: begin
          if (!rdata[7] && !(px[5:0] == cx && py[5:0] == cy && !walking)) begin
            res <= o; state <= S_WRITE;
          end else if (scan_end) state <= S_WRITE;
          else state <= S_SCAN;
        end
        S_WRITE: begin
          walking <= 1'b1;
          if (lim > 7'd1 && wo < lim) state <= S_WALK;
          else begin
            cnt <= '0; mx <= '0; state <= S_MAX;
          end
        end
        S_WALK: begin
          if (qin) state <= S_WALKRD;
          else begin
            wd <= wd + 1'b1;
            if (wd == 3'd7) wo <= wo + 1'b1;
            if (wd == 3'd7 && wo + 7'd1 >= lim) begin
              cnt <= '0; mx <= '0; state <= S_MAX;
            end
          end
        end
        S_WALKRD: begin
          wd <= wd + 1'b1;
          if (wd == 3'd7) wo <= wo + 1'b1;
          if (rdata[7]) begin
            tx <= qx[5:0]; ty <= qy[5:0]; cur <= addr_of(qx[5:0], qy[5:0]);
            o <= 7'd1; d <= 3'd0; res <= rdg_pkg::ValueSat;
            state <= S_SCAN;
          end else if (wd == 3'd7 && wo + 7'd1 >= lim) begin
            cnt <= '0; mx <= '0; state <= S_MAX;
          end else state <= S_WALK;
        end
        S_MAX: begin
          // pipelined sweep: rdata is the registered read of the raddr before it
          cnt <= cnt + 1'b1;
          if (cnt != '0) begin
            if ({1'b0, prev_x} < w && {1'b0, prev_y} < h && rdata[6:0] > mx) mx <= rdata[6:0];
          end
          if (cnt == (AW+1)'(rdg_pkg::Depth)) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          out.cell_active <= rdata[7] && {1'b0, cx} < w && {1'b0, cy} < h;
          out.cell_value <= ({1'b0, cx} < w && {1'b0, cy} < h && rdata[7]) ? rdata[6:0] : 7'd0;
          out.largest_value <= mx;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_SCAN && !pin) begin
        d <= d + 1'b1;
        if (d == 3'd7) o <= o + 1'b1;
      end
      if (state == S_SCANRD && !(!rdata[7] && !(px[5:0] == cx && py[5:0] == cy && !walking))) begin
        d <= d + 1'b1;
        if (d == 3'd7) o <= o + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_x <= mxx;
    prev_y <= mxy;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("accept while busy");
  a_rsp_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> rsp.valid) else $error("missing result");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we) else $error("write while idle");
endmodule
